### hdl/first_fit_segment_allocator_macros.svh
// assertion macros for the first-fit segment allocator
// no dependencies; included by modules that carry assertions
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define FFSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define FFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/ffsa_pkg.sv
// shared types and constants for the first-fit segment allocator
// no dependencies
package ffsa_pkg;

	localparam int unsigned DefMaxSegments = 16;
	localparam int unsigned DefAddrWidth   = 16;
	localparam logic [15:0] TotalSizeReset = 16'd1024;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_INIT  = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOFIT    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_BADSIZE  = 3'd4;

	// commands from controller to datapath
	typedef struct packed {
		logic load_req;    // capture request fields
		logic init_table;  // rebuild one free segment
		logic clr_idx;     // scan index to zero
		logic inc_idx;     // advance scan index
		logic mark_hit;    // rewrite found entry (alloc or free)
		logic shift_up;    // move entry idx-1 to idx, idx decrements
		logic shift_down;  // move entry idx+1 to idx, idx increments
		logic write_ins;   // write inserted free entry at idx
		logic merge_prev;  // add entry idx length to idx-1, target to idx-1
		logic merge_next;  // add entry idx+1 length to idx, idx increments
		logic restore_idx; // scan index back to saved target
		logic set_result;  // load result register
		logic [2:0] res_status;
		logic cnt_inc;
		logic cnt_dec;
	} ffsa_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] mode;
		logic size_zero;
		logic idx_end;      // idx >= count
		logic alloc_hit;    // entry idx fits allocate
		logic free_hit;     // entry idx is used and starts at address
		logic need_split;   // fitting entry longer than request
		logic table_full;   // count == max
		logic prev_free;    // idx > 0 and entry idx-1 free
		logic next_free;    // idx+1 < count and entry idx+1 free
		logic at_target;    // idx == saved target position + 1
		logic del_end;      // idx+1 >= count
	} ffsa_stat_t;

endpackage

### hdl/ffsa_datapath.sv
// segment table, scan index and result registers of the allocator
// depends on ffsa_pkg
module ffsa_datapath #(
	parameter int unsigned MAX_SEGMENTS = ffsa_pkg::DefMaxSegments,
	parameter int unsigned ADDR_WIDTH   = ffsa_pkg::DefAddrWidth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [15:0]           total_size_q,
	input  logic [1:0]            mode,
	input  logic [15:0]           request_size,
	input  logic [15:0]           block_start,
	input  ffsa_pkg::ffsa_cmd_t   cmd,
	output ffsa_pkg::ffsa_stat_t  stat,
	output logic [2:0]            status,
	output logic [15:0]           grant_start,
	output logic [15:0]           grant_size
);
	import ffsa_pkg::*;

	localparam int unsigned IW = $clog2(MAX_SEGMENTS);
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

	logic [ADDR_WIDTH-1:0] start_mem [MAX_SEGMENTS];
	logic [ADDR_WIDTH-1:0] len_mem   [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] free_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] tgt_q;
	logic [1:0]  mode_q;
	logic [ADDR_WIDTH-1:0] size_q, addr_q;
	logic [ADDR_WIDTH-1:0] rest_q;
	logic [2:0]  status_q;
	logic [15:0] gs_q, gz_q;

	logic [IW-1:0] ix, ixm1, ixp1;
	logic [ADDR_WIDTH-1:0] cur_start, cur_len, prv_len, nxt_len;
	logic cur_free;
	logic [CW:0] idx_p1;

	assign ix     = idx_q[IW-1:0];
	assign ixm1   = ix - IW'(1);
	assign ixp1   = ix + IW'(1);
	assign idx_p1 = {1'b0, idx_q} + (CW+1)'(1);
	assign cur_start = start_mem[ix];
	assign cur_len   = len_mem[ix];
	assign cur_free  = free_q[ix];
	assign prv_len   = len_mem[ixm1];
	assign nxt_len   = len_mem[ixp1];

	// status toward the controller
	always_comb begin
		stat.mode       = mode_q;
		stat.size_zero  = (size_q == '0);
		stat.idx_end    = (idx_q >= count_q);
		stat.alloc_hit  = cur_free && (cur_len >= size_q);
		stat.free_hit   = !cur_free && (cur_start == addr_q);
		stat.need_split = (cur_len != size_q);
		stat.table_full = (count_q >= CW'(MAX_SEGMENTS));
		stat.prev_free  = (idx_q != '0) && free_q[ixm1];
		stat.next_free  = (idx_p1 < {1'b0, count_q}) && free_q[ixp1];
		stat.at_target  = (idx_q == tgt_q + CW'(1));
		stat.del_end    = (idx_p1 >= {1'b0, count_q});
	end

	// request capture, index, count and target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(1);
			idx_q   <= '0;
			tgt_q   <= '0;
			mode_q  <= MODE_ALLOC;
			free_q  <= MAX_SEGMENTS'(1);
		end else begin
			if (cmd.load_req) begin
				mode_q <= mode;
			end
			if (cmd.init_table) begin
				count_q <= CW'(1);
				free_q  <= MAX_SEGMENTS'(1);
			end
			if (cmd.cnt_inc) count_q <= count_q + CW'(1);
			if (cmd.cnt_dec) count_q <= count_q - CW'(1);
			if (cmd.clr_idx) idx_q <= '0;
			// on a hit remember the position; an allocate also goes to the table end for shifting
			if (cmd.inc_idx) idx_q <= idx_q + CW'(1);
			if (cmd.mark_hit) begin
				tgt_q <= idx_q;
				free_q[ix] <= (mode_q == MODE_FREE);
				if (mode_q == MODE_ALLOC) idx_q <= count_q;
			end
			if (cmd.shift_up) begin
				free_q[ix] <= free_q[ixm1];
				idx_q <= idx_q - CW'(1);
			end
			if (cmd.shift_down) begin
				free_q[ix] <= free_q[ixp1];
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.write_ins) free_q[ix] <= 1'b1;
			// merged entry stays at idx-1, idx is the entry to delete
			if (cmd.merge_prev) tgt_q <= idx_q - CW'(1);
			if (cmd.merge_next) idx_q <= idx_q + CW'(1);
			if (cmd.restore_idx) idx_q <= tgt_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			size_q <= ADDR_WIDTH'(request_size);
			addr_q <= ADDR_WIDTH'(block_start);
		end
		// remainder of a split, kept for the inserted free entry
		if (cmd.mark_hit && mode_q == MODE_ALLOC) begin
			rest_q <= cur_len - size_q;
		end
		if (cmd.set_result) begin
			status_q <= cmd.res_status;
			if (cmd.res_status == ST_OK && mode_q == MODE_ALLOC) begin
				gs_q <= 16'(cmd.mark_hit ? cur_start : start_mem[tgt_q[IW-1:0]]);
				gz_q <= 16'(size_q);
			end else begin
				gs_q <= '0;
				gz_q <= '0;
			end
		end
	end

	// segment table, one write port
	always_ff @(posedge clk) begin
		if (cmd.init_table) begin
			start_mem[0] <= '0;
			len_mem[0]   <= ADDR_WIDTH'(total_size_q);
		end else if (cmd.mark_hit && mode_q == MODE_ALLOC) begin
			len_mem[ix] <= size_q;
		end else if (cmd.shift_up) begin
			start_mem[ix] <= start_mem[ixm1];
			len_mem[ix]   <= prv_len;
		end else if (cmd.shift_down) begin
			start_mem[ix] <= start_mem[ixp1];
			len_mem[ix]   <= nxt_len;
		end else if (cmd.write_ins) begin
			start_mem[ix] <= start_mem[ixm1] + size_q;
			len_mem[ix]   <= rest_q;
		end else if (cmd.merge_prev) begin
			len_mem[ixm1] <= prv_len + cur_len;
		end else if (cmd.merge_next) begin
			len_mem[ix] <= cur_len + nxt_len;
		end
	end

	assign status      = status_q;
	assign grant_start = gs_q;
	assign grant_size  = gz_q;
endmodule

### hdl/ffsa_ctrl.sv
// controller state machine of the allocator
// depends on ffsa_pkg and the assertion macro header
module ffsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ffsa_pkg::ffsa_stat_t stat,
	output ffsa_pkg::ffsa_cmd_t  cmd
);
	import ffsa_pkg::*;
	`include "first_fit_segment_allocator_macros.svh"

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DISP  = 10'b0000000010,
		S_SCAN  = 10'b0000000100,
		S_SHUP  = 10'b0000001000,
		S_MPREV = 10'b0000010000,
		S_MNEXT = 10'b0000100000,
		S_DEL   = 10'b0001000000,
		S_INIT  = 10'b0010000000,
		S_DONE  = 10'b0100000000,
		S_BOOT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   next_done_q;
	logic   del_cnt;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		del_cnt = 1'b0;
		case (state_q)
			// build the table once after reset
			S_BOOT: begin
				cmd.init_table = 1'b1;
				state_d        = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load_req = 1'b1;
					cmd.clr_idx  = 1'b1;
					state_d      = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.mode == MODE_INIT) begin
					cmd.init_table = 1'b1;
					state_d        = S_INIT;
				end else if (stat.mode == MODE_ALLOC && stat.size_zero) begin
					cmd.set_result = 1'b1;
					cmd.res_status = ST_BADSIZE;
					state_d        = S_DONE;
				end else if (stat.mode == MODE_ALLOC || stat.mode == MODE_FREE) begin
					state_d = S_SCAN;
				end else begin
					cmd.set_result = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_DONE;
				end
			end
			S_INIT: begin
				cmd.set_result = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_DONE;
			end
			S_SCAN: begin
				if (stat.idx_end) begin
					cmd.set_result = 1'b1;
					cmd.res_status = (stat.mode == MODE_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
					state_d        = S_DONE;
				end else if (stat.mode == MODE_ALLOC && stat.alloc_hit) begin
					if (stat.need_split && stat.table_full) begin
						cmd.set_result = 1'b1;
						cmd.res_status = ST_FULL;
						state_d        = S_DONE;
					end else if (stat.need_split) begin
						cmd.mark_hit = 1'b1;
						cmd.cnt_inc  = 1'b1;
						state_d      = S_SHUP;
					end else begin
						cmd.mark_hit   = 1'b1;
						cmd.set_result = 1'b1;
						cmd.res_status = ST_OK;
						state_d        = S_DONE;
					end
				end else if (stat.mode == MODE_FREE && stat.free_hit) begin
					cmd.mark_hit = 1'b1;
					state_d      = S_MPREV;
				end else begin
					cmd.inc_idx = 1'b1;
				end
			end
			// open a hole right after the allocated entry, then fill it
			S_SHUP: begin
				if (stat.at_target) begin
					cmd.write_ins  = 1'b1;
					cmd.set_result = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_DONE;
				end else begin
					cmd.shift_up = 1'b1;
				end
			end
			S_MPREV: begin
				if (stat.prev_free) begin
					cmd.merge_prev = 1'b1;
					del_cnt        = 1'b1;
					state_d        = S_DEL;
				end else begin
					state_d = S_MNEXT;
				end
			end
			S_MNEXT: begin
				if (stat.next_free) begin
					cmd.merge_next = 1'b1;
					del_cnt        = 1'b1;
					state_d        = S_DEL;
				end else begin
					cmd.set_result = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_DONE;
				end
			end
			// close the gap left by a merged entry
			S_DEL: begin
				if (stat.del_end) begin
					cmd.cnt_dec     = 1'b1;
					cmd.restore_idx = 1'b1;
					if (next_done_q) begin
						cmd.set_result = 1'b1;
						cmd.res_status = ST_OK;
						state_d        = S_DONE;
					end else begin
						state_d = S_MNEXT;
					end
				end else begin
					cmd.shift_down = 1'b1;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (del_cnt) cmd.cnt_dec = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_BOOT;
			out_valid_q <= 1'b0;
			next_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.set_result) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			// at most one merge with the following entry per item
			if (cmd.load_req) next_done_q <= 1'b0;
			else if (cmd.merge_next) next_done_q <= 1'b1;
		end
	end

	`FFSA_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`FFSA_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !in_ready)
	`FFSA_ASSERT_NEXT(a_result_shown, clk, arst_n, cmd.set_result, out_valid)
endmodule

### hdl/first_fit_segment_allocator.sv
// First-fit segment allocator with coalescing. An item passes accept, dispatch and
// done, and in between one step per table entry scanned, one per entry shifted on
// a split or merge and one per merge check; the controller walks the segment table,
// which has one write port, one entry per cycle. A boot state after reset builds
// the table before the first item is taken. One item is handled at a time; its
// result waits in an output register.
// depends on ffsa_pkg, ffsa_ctrl and ffsa_datapath
module first_fit_segment_allocator #(
	parameter int unsigned MAX_SEGMENTS = ffsa_pkg::DefMaxSegments,
	parameter int unsigned ADDR_WIDTH   = ffsa_pkg::DefAddrWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [15:0] request_size,
	input  logic [15:0] block_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] grant_start,
	output logic [15:0] grant_size
);
	import ffsa_pkg::*;

	logic [15:0] total_size_q;
	ffsa_cmd_t   cmd;
	ffsa_stat_t  stat;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) total_size_q <= TotalSizeReset;
		else if (cfg_we) total_size_q <= cfg_wdata;
	end

	ffsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	ffsa_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_WIDTH(ADDR_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .total_size_q(total_size_q), .mode(mode),
		.request_size(request_size), .block_start(block_start), .cmd(cmd),
		.stat(stat), .status(status), .grant_start(grant_start),
		.grant_size(grant_size)
	);
endmodule

### tb/testbench.sv
// self-checking testbench for first_fit_segment_allocator
// depends on ffsa_pkg and the allocator rtl; carries its own segment table predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ffsa_pkg::*;

	localparam int NSEG = 16;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] gstart;
		logic [15:0] gsize;
	} grant_t;

	// predictor of the segment table plus queue of pending grants
	class alloc_scoreboard;
		logic [15:0] seg_base[NSEG];
		logic [15:0] seg_len[NSEG];
		bit          seg_free[NSEG];
		int          seg_cnt;
		logic [15:0] mem_size;
		grant_t      pending_grants[$];
		int          errors;

		function void rebuild();
			for (int k = 0; k < NSEG; k++) begin
				seg_base[k] = '0;
				seg_len[k] = '0;
				seg_free[k] = 0;
			end
			seg_len[0] = mem_size;
			seg_free[0] = 1;
			seg_cnt = 1;
		endfunction

		function void drop_entry(int pos);
			for (int k = pos; k + 1 < seg_cnt; k++) begin
				seg_base[k] = seg_base[k+1];
				seg_len[k] = seg_len[k+1];
				seg_free[k] = seg_free[k+1];
			end
			seg_cnt--;
		endfunction

		function grant_t try_alloc(logic [15:0] sz);
			grant_t g;
			logic [15:0] rest;
			g = '0;
			if (sz == 0) begin
				g.status = ST_BADSIZE;
				return g;
			end
			for (int i = 0; i < seg_cnt; i++) begin
				if (seg_free[i] && seg_len[i] >= sz) begin
					rest = seg_len[i] - sz;
					if (rest != 0 && seg_cnt >= NSEG) begin
						g.status = ST_FULL;
						return g;
					end
					seg_free[i] = 0;
					seg_len[i] = sz;
					if (rest != 0) begin
						for (int k = seg_cnt; k > i + 1; k--) begin
							seg_base[k] = seg_base[k-1];
							seg_len[k] = seg_len[k-1];
							seg_free[k] = seg_free[k-1];
						end
						seg_base[i+1] = seg_base[i] + sz;
						seg_len[i+1] = rest;
						seg_free[i+1] = 1;
						seg_cnt++;
					end
					g.status = ST_OK;
					g.gstart = seg_base[i];
					g.gsize = sz;
					return g;
				end
			end
			g.status = ST_NOFIT;
			return g;
		endfunction

		function logic [2:0] try_release(logic [15:0] addr);
			int i;
			for (i = 0; i < seg_cnt; i++) begin
				if (!seg_free[i] && seg_base[i] == addr) begin
					seg_free[i] = 1;
					if (i > 0 && seg_free[i-1]) begin
						seg_len[i-1] = seg_len[i-1] + seg_len[i];
						drop_entry(i);
						i--;
					end
					if (i + 1 < seg_cnt && seg_free[i+1]) begin
						seg_len[i] = seg_len[i] + seg_len[i+1];
						drop_entry(i + 1);
					end
					return ST_OK;
				end
			end
			return ST_NOTFOUND;
		endfunction

		function void note_request(logic [1:0] m, logic [15:0] sz, logic [15:0] addr);
			grant_t g;
			g = '0;
			if (m == MODE_ALLOC) g = try_alloc(sz);
			else if (m == MODE_FREE) g.status = try_release(addr);
			else if (m == MODE_INIT) rebuild();
			pending_grants = {pending_grants, g};
		endfunction

		function void check_grant(grant_t got);
			grant_t exp;
			if (pending_grants.size() == 0) begin
				$error("unexpected item status=%0d", got.status);
				errors++;
				return;
			end
			exp = pending_grants.pop_front();
			if (got.status !== exp.status) begin
				$error("status expected %0d actual %0d", exp.status, got.status);
				errors++;
			end
			if (got.gstart !== exp.gstart) begin
				$error("grant_start expected %0d actual %0d", exp.gstart, got.gstart);
				errors++;
			end
			if (got.gsize !== exp.gsize) begin
				$error("grant_size expected %0d actual %0d", exp.gsize, got.gsize);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [15:0] request_size;
	logic [15:0] block_start;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [15:0] grant_start;
	logic [15:0] grant_size;

	alloc_scoreboard sb;
	bit  hold_off;
	bit  stim_done;
	int  idle_cycles;
	logic [15:0] used_bases[$];

	first_fit_segment_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.request_size(request_size), .block_start(block_start),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.grant_start(grant_start), .grant_size(grant_size)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// offer one item and wait for acceptance
	task automatic send_request(logic [1:0] m, logic [15:0] sz, logic [15:0] addr);
		in_valid <= 1'b1;
		mode <= m;
		request_size <= sz;
		block_start <= addr;
		do @(posedge clk); while (!in_ready);
		sb.note_request(m, sz, addr);
	endtask

	task automatic idle_input(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait for every pending grant, then give the block time to settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_grants.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_size(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mem_size = v;
	endtask

	// pick a free address: mostly a live used base, otherwise noise
	function automatic logic [15:0] pick_release();
		int j;
		if (used_bases.size() != 0 && $urandom_range(0, 9) < 8) begin
			j = $urandom_range(0, used_bases.size() - 1);
			pick_release = used_bases[j];
			used_bases.delete(j);
		end else begin
			pick_release = 16'($urandom);
		end
	endfunction

	// mostly well-formed alloc/free traffic with random content
	task automatic random_phase(int n, int max_sz);
		logic [1:0] m;
		logic [15:0] sz;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			sz = 16'($urandom_range(1, max_sz));
			if (r < 3) sz = 16'($urandom);
			if (r == 4) sz = '0;
			if (r < 50) m = MODE_ALLOC;
			else if (r < 94) m = MODE_FREE;
			else if (r < 97) m = MODE_INIT;
			else m = 2'd3;
			if (m == MODE_INIT) used_bases.delete();
			send_request(m, sz, (m == MODE_FREE) ? pick_release() : 16'($urandom));
			if (m == MODE_ALLOC && sb.pending_grants[$].status == ST_OK)
				used_bases = {used_bases, sb.pending_grants[$].gstart};
			if ($urandom_range(0, 7) == 0) idle_input($urandom_range(1, 12));
		end
	endtask

	// receiver: stall pattern plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= !hold_off && ($urandom_range(0, 3) != 0 || stim_done);
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_grant({status, grant_start, grant_size});
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		sb = new();
		sb.mem_size = TotalSizeReset;
		sb.rebuild();
		sb.errors = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		mode = MODE_ALLOC;
		request_size = '0;
		block_start = '0;
		hold_off = 0;
		stim_done = 0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero size, exact fit, split, frees with merges, unknown starts, undefined mode, init
		send_request(MODE_ALLOC, 16'd0, 16'd0);
		send_request(MODE_ALLOC, 16'd1, 16'd0);
		send_request(MODE_ALLOC, 16'd100, 16'd0);
		send_request(MODE_ALLOC, 16'd2000, 16'd0);
		send_request(MODE_FREE, 16'd0, 16'd1);
		send_request(MODE_FREE, 16'd0, 16'd500);
		send_request(MODE_FREE, 16'd0, 16'd0);
		send_request(MODE_FREE, 16'd0, 16'd101);
		send_request(MODE_ALLOC, 16'd1024, 16'd0);
		send_request(MODE_FREE, 16'd0, 16'hffff);
		send_request(MODE_FREE, 16'd0, 16'd0);
		send_request(2'd3, 16'hffff, 16'hffff);
		send_request(MODE_INIT, 16'h5555, 16'haaaa);
		// fill the table with single-unit splits until it reports full
		for (int k = 0; k < 16; k++) send_request(MODE_ALLOC, 16'd1, 16'd0);
		send_request(MODE_ALLOC, 16'd2000, 16'd0);
		drain();

		// zero memory size
		write_size(16'd0);
		send_request(MODE_INIT, 16'd0, 16'd0);
		send_request(MODE_ALLOC, 16'd1, 16'd0);
		drain();

		// full-range memory, split remainder at the top address
		write_size(16'hffff);
		send_request(MODE_INIT, 16'd0, 16'd0);
		send_request(MODE_ALLOC, 16'hfffe, 16'd0);
		send_request(MODE_ALLOC, 16'hffff, 16'd0);
		send_request(MODE_ALLOC, 16'd1, 16'd0);
		send_request(MODE_FREE, 16'd0, 16'hfffe);
		send_request(MODE_FREE, 16'd0, 16'd0);
		drain();

		// random phases under several memory sizes
		write_size(16'd300);
		send_request(MODE_INIT, 16'd0, 16'd0);
		used_bases.delete();
		random_phase(300, 40);
		// long receiver hold-off while items keep coming
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			random_phase(20, 40);
		join
		drain();

		write_size(16'd1);
		send_request(MODE_INIT, 16'd0, 16'd0);
		used_bases.delete();
		random_phase(60, 2);
		drain();

		write_size(16'hffff);
		send_request(MODE_INIT, 16'd0, 16'd0);
		used_bases.delete();
		random_phase(350, 8000);
		drain();

		write_size(16'd5000);
		send_request(MODE_INIT, 16'd0, 16'd0);
		used_bases.delete();
		random_phase(350, 600);

		stim_done = 1;
		in_valid <= 1'b0;
		while (sb.pending_grants.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

### first_fit_segment_allocator.f
+incdir+hdl
hdl/ffsa_pkg.sv
hdl/ffsa_datapath.sv
hdl/ffsa_ctrl.sv
hdl/first_fit_segment_allocator.sv
tb/testbench.sv
